FILE: src/mcrr_pkg.sv
// Shared types, constants and state codes for the multi-client record ring.
package mcrr_pkg;

    localparam int CLIENTS_DEF     = 4;
    localparam int RING_FRAMES_DEF = 1024;
    localparam int MAX_BURST_DEF   = 32;

    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_SERVICE = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;
    localparam logic [1:0] FUNC_STOP    = 2'd3;

    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_RECORD   = 3'd1;
    localparam logic [2:0] MODE_STOP_REQ = 3'd2;
    localparam logic [2:0] MODE_DRAIN    = 3'd3;
    localparam logic [2:0] MODE_FINAL    = 3'd4;
    localparam logic [2:0] MODE_READY    = 3'd5;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_INVALID  = 2'd2;

    localparam logic [23:0] MAX24 = 24'hFFFFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [1:0]  res_client;
        logic [23:0] out_left;
        logic [23:0] out_right;
        logic        last;
        logic        accepted;
        logic [2:0]  client_state;
        logic [1:0]  error_code;
        logic [9:0]  pending_frames;
        logic [15:0] ovf_total;
        logic [23:0] drop_total;
        logic [23:0] drain_total;
    } result_t;

endpackage

FILE: src/mcrr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module mcrr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/multi_client_record_ring_top.sv
// Top level of the multi-client record ring: sequencer, client state and frame store.
//
// Input channel s_axis_*: one transaction per operation (push, service, start, stop).
// Output channel m_axis_*: one or more result transactions per operation; tlast marks
// the last result of an operation, tuser carries kind (1 = drained frame).
// Push, start and stop give one status result. A service scans all clients one per
// cycle for stop conversion and arbitration, then drains up to the budget from the
// client with most pending frames, reading one frame at a time from the single frame
// store port (request, wait and output states, held while the output register is
// busy), then scans clients again for the finalize step. One operation is in flight
// at a time: s_axis_tready is low from acceptance until the last result is taken,
// or for a service with no drained frame until its status result is loaded.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset clears all client state; the frame store needs no clearing.
module multi_client_record_ring_top #(
    parameter int CLIENTS     = mcrr_pkg::CLIENTS_DEF,
    parameter int RING_FRAMES = mcrr_pkg::RING_FRAMES_DEF,
    parameter int MAX_BURST   = mcrr_pkg::MAX_BURST_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], client[3:2], left[27:4], right[51:28], block_len[61:52],
    // frame_budget[67:62], take limit[91:68], zero fill
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_client[1:0], out_left[25:2], out_right[49:26], accepted[50],
    // client_state[53:51], error_code[55:54], pending_frames[65:56],
    // ovf_total[81:66], drop_total[105:82], drain_total[129:106], zero fill
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // kind
    output logic         m_axis_tuser
);

    localparam int CW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int PW  = $clog2(RING_FRAMES);
    localparam int AW  = CW + PW;
    localparam int BW  = $clog2(MAX_BURST + 1);
    localparam logic [PW-1:0] FULL = PW'(RING_FRAMES - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_OP     = 8'b00000010,
        S_SCAN   = 8'b00000100,
        S_RDREQ  = 8'b00001000,
        S_RDWAIT = 8'b00010000,
        S_RDOUT  = 8'b00100000,
        S_FIN    = 8'b01000000,
        S_EMIT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  mode_reg   [CLIENTS];
    logic [1:0]  fault_reg  [CLIENTS];
    logic        half_reg   [CLIENTS];
    logic [PW-1:0] wpos_reg [CLIENTS];
    logic [PW-1:0] rpos_reg [CLIENTS];
    logic [23:0] recv_reg   [CLIENTS];
    logic [23:0] limit_reg  [CLIENTS];
    logic [15:0] ovf_reg    [CLIENTS];
    logic [23:0] drop_reg   [CLIENTS];
    logic [23:0] wr_reg     [CLIENTS];
    logic [9:0]  keep_reg   [CLIENTS];

    logic [95:0] in_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] best_reg;
    logic          best_v_reg;
    logic [PW-1:0] best_p_reg;
    logic [BW-1:0] cnt_reg;
    logic          stepped_v_reg;
    logic [CW-1:0] stepped_reg;
    logic          drained_reg;

    mcrr_pkg::result_t res_reg;
    logic              res_v_reg;

    logic [1:0]  f_func;
    logic [1:0]  f_client;
    logic [23:0] f_left, f_right, f_lim;
    logic [9:0]  f_blen;
    logic [5:0]  f_budget;
    assign f_func   = in_reg[1:0];
    assign f_client = in_reg[3:2];
    assign f_left   = in_reg[27:4];
    assign f_right  = in_reg[51:28];
    assign f_blen   = in_reg[61:52];
    assign f_budget = in_reg[67:62];
    assign f_lim    = in_reg[91:68];

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [47:0]   ram_rdata;

    mcrr_ram #(.WIDTH(48), .DEPTH(CLIENTS * RING_FRAMES)) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data({f_right, f_left}),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    function automatic logic [PW-1:0] pend_f(logic [PW-1:0] w, logic [PW-1:0] r);
        logic [PW:0] d;
        d = {1'b0, w} + (PW+1)'(RING_FRAMES) - {1'b0, r};
        if (d >= (PW+1)'(RING_FRAMES)) d = d - (PW+1)'(RING_FRAMES);
        return d[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] inc_f(logic [PW-1:0] p);
        return (p == FULL) ? '0 : p + 1'b1;
    endfunction

    // client selected by the sequencer
    logic [CW-1:0] cur;
    logic          cvalid;
    always_comb begin
        cur = idx_reg;
        cvalid = 1'b1;
        if (state_reg == S_OP) begin
            cur = f_client[CW-1:0];
            cvalid = ({30'd0, f_client} < 32'(CLIENTS));
        end else if (state_reg == S_RDREQ || state_reg == S_RDWAIT || state_reg == S_RDOUT) begin
            cur = best_reg;
        end
    end

    logic [PW-1:0] cpend;
    assign cpend = pend_f(wpos_reg[cur], rpos_reg[cur]);

    logic [BW-1:0] budget_c;
    assign budget_c = ({26'd0, f_budget} > 32'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(f_budget);

    logic [PW-1:0] ncount;
    always_comb begin
        ncount = best_p_reg;
        if ({{(32-BW){1'b0}}, budget_c} < {{(32-PW){1'b0}}, best_p_reg})
            ncount = PW'(budget_c);
    end

    assign ram_raddr = {best_reg, rpos_reg[best_reg]};
    assign ram_waddr = {cur, wpos_reg[cur]};

    // push decision
    logic        p_store, p_acc, p_ovf;
    logic [1:0]  p_fault;
    logic [9:0]  p_keep;
    logic [23:0] p_n, p_rem;
    logic [PW:0] p_avail;
    always_comb begin
        p_store = 1'b0; p_acc = 1'b0; p_ovf = 1'b0;
        p_fault = fault_reg[cur];
        p_keep  = keep_reg[cur];
        p_n     = {14'd0, f_blen};
        p_rem   = limit_reg[cur] - recv_reg[cur];
        p_avail = {1'b0, FULL} - {1'b0, cpend};
        if (f_blen != 10'd0) begin
            p_keep = '0;
            if (mode_reg[cur] != mcrr_pkg::MODE_RECORD) begin
                p_fault = mcrr_pkg::ERR_INVALID;
            end else begin
                if (limit_reg[cur] != 24'd0) begin
                    if (recv_reg[cur] >= limit_reg[cur]) p_n = '0;
                    else if (p_n > p_rem) p_n = p_rem;
                end
                if ({{(24-PW-1){1'b0}}, p_avail} < p_n) begin
                    p_ovf = 1'b1;
                    p_fault = mcrr_pkg::ERR_OVERFLOW;
                end else begin
                    p_acc = 1'b1;
                    p_keep = p_n[9:0];
                    if (p_n != 24'd0) begin
                        if (cpend >= FULL) p_keep = '0;
                        else begin
                            p_store = 1'b1;
                            p_keep = p_n[9:0] - 10'd1;
                        end
                    end
                end
            end
        end else if (mode_reg[cur] != mcrr_pkg::MODE_RECORD &&
                     mode_reg[cur] != mcrr_pkg::MODE_STOP_REQ &&
                     mode_reg[cur] != mcrr_pkg::MODE_DRAIN) begin
            p_keep = '0;
            p_fault = mcrr_pkg::ERR_INVALID;
        end else if (keep_reg[cur] != 10'd0) begin
            if (cpend >= FULL) p_keep = '0;
            else begin
                p_store = 1'b1;
                p_acc = 1'b1;
                p_keep = keep_reg[cur] - 10'd1;
            end
        end
    end

    assign ram_we = (state_reg == S_OP) && cvalid && f_func == mcrr_pkg::FUNC_PUSH && p_store;

    logic out_free;
    assign out_free = !res_v_reg || m_axis_tready;
    logic last_idx;
    assign last_idx = ({{(32-CW){1'b0}}, idx_reg} == 32'(CLIENTS - 1));

    mcrr_pkg::result_t status;
    always_comb begin
        status = '0;
        status.res_client   = 2'(cur);
        status.client_state = mode_reg[cur];
        status.error_code   = fault_reg[cur];
        status.pending_frames = 10'(cpend);
        status.ovf_total = ovf_reg[cur];
        status.drop_total = drop_reg[cur];
        status.drain_total = wr_reg[cur];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_axis_tvalid) state_next = S_OP;
            S_OP:     if (out_free) state_next = (f_func == mcrr_pkg::FUNC_SERVICE) ? S_SCAN : S_EMIT;
            S_SCAN:   if (last_idx) state_next = S_RDREQ;
            S_RDREQ:  state_next = (cnt_reg == BW'(ncount) || !best_v_reg) ? S_FIN : S_RDWAIT;
            S_RDWAIT: if (out_free) state_next = S_RDOUT;
            S_RDOUT:  if (out_free) state_next = S_RDREQ;
            S_FIN:    if (last_idx) state_next = drained_reg ? S_EMIT : S_EMIT;
            S_EMIT:   if (!res_v_reg || m_axis_tready) state_next = (res_v_reg && !drained_reg) ? S_EMIT : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_v_reg <= 1'b0;
            idx_reg <= '0;
            for (int i = 0; i < CLIENTS; i++) begin
                mode_reg[i] <= mcrr_pkg::MODE_IDLE;
                fault_reg[i] <= mcrr_pkg::ERR_NONE;
                half_reg[i] <= 1'b0;
                wpos_reg[i] <= '0; rpos_reg[i] <= '0;
                recv_reg[i] <= '0; limit_reg[i] <= '0;
                ovf_reg[i] <= '0; drop_reg[i] <= '0;
                wr_reg[i] <= '0; keep_reg[i] <= '0;
            end
        end else begin
            if (res_v_reg && m_axis_tready) res_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) in_reg <= s_axis_tdata;
                    idx_reg <= '0;
                    best_v_reg <= 1'b0; best_p_reg <= '0; best_reg <= '0;
                    cnt_reg <= '0; stepped_v_reg <= 1'b0; stepped_reg <= '0;
                    drained_reg <= 1'b0;
                end
                S_OP: begin
                    if (out_free && f_func != mcrr_pkg::FUNC_SERVICE) begin
                        res_v_reg <= 1'b1;
                        res_reg <= '0;
                        res_reg.res_client <= f_client;
                        res_reg.last <= 1'b1;
                        res_reg.error_code <= mcrr_pkg::ERR_INVALID;
                        drained_reg <= 1'b1;
                        if (cvalid) begin
                            case (f_func)
                                mcrr_pkg::FUNC_PUSH: begin
                                    keep_reg[cur] <= p_keep;
                                    fault_reg[cur] <= p_fault;
                                    if (p_ovf) begin
                                        if (ovf_reg[cur] != mcrr_pkg::MAX16)
                                            ovf_reg[cur] <= ovf_reg[cur] + 16'd1;
                                        drop_reg[cur] <= ({1'b0, drop_reg[cur]} + {1'b0, p_n} > {1'b0, mcrr_pkg::MAX24})
                                            ? mcrr_pkg::MAX24 : drop_reg[cur] + p_n;
                                    end
                                    if (p_store) begin
                                        wpos_reg[cur] <= inc_f(wpos_reg[cur]);
                                        if (recv_reg[cur] != mcrr_pkg::MAX24)
                                            recv_reg[cur] <= recv_reg[cur] + 24'd1;
                                    end
                                    res_reg <= status;
                                    res_reg.last <= 1'b1;
                                    res_reg.accepted <= p_acc;
                                    res_reg.error_code <= p_fault;
                                    res_reg.pending_frames <= 10'(p_store ? pend_f(inc_f(wpos_reg[cur]), rpos_reg[cur]) : cpend);
                                    if (p_ovf) begin
                                        res_reg.ovf_total <= (ovf_reg[cur] != mcrr_pkg::MAX16) ? ovf_reg[cur] + 16'd1 : ovf_reg[cur];
                                        res_reg.drop_total <= ({1'b0, drop_reg[cur]} + {1'b0, p_n} > {1'b0, mcrr_pkg::MAX24})
                                            ? mcrr_pkg::MAX24 : drop_reg[cur] + p_n;
                                    end
                                end
                                mcrr_pkg::FUNC_START: begin
                                    res_reg <= status;
                                    res_reg.last <= 1'b1;
                                    if (mode_reg[cur] == mcrr_pkg::MODE_IDLE || mode_reg[cur] == mcrr_pkg::MODE_READY) begin
                                        wpos_reg[cur] <= '0; rpos_reg[cur] <= '0;
                                        recv_reg[cur] <= '0; ovf_reg[cur] <= '0;
                                        drop_reg[cur] <= '0; wr_reg[cur] <= '0;
                                        keep_reg[cur] <= '0; half_reg[cur] <= 1'b0;
                                        fault_reg[cur] <= mcrr_pkg::ERR_NONE;
                                        limit_reg[cur] <= f_lim;
                                        mode_reg[cur] <= mcrr_pkg::MODE_RECORD;
                                        res_reg.accepted <= 1'b1;
                                        res_reg.client_state <= mcrr_pkg::MODE_RECORD;
                                        res_reg.error_code <= mcrr_pkg::ERR_NONE;
                                        res_reg.pending_frames <= '0;
                                        res_reg.ovf_total <= '0;
                                        res_reg.drop_total <= '0;
                                        res_reg.drain_total <= '0;
                                    end else begin
                                        fault_reg[cur] <= mcrr_pkg::ERR_INVALID;
                                        res_reg.error_code <= mcrr_pkg::ERR_INVALID;
                                    end
                                end
                                default: begin
                                    res_reg <= status;
                                    res_reg.last <= 1'b1;
                                    if (mode_reg[cur] == mcrr_pkg::MODE_RECORD) begin
                                        mode_reg[cur] <= mcrr_pkg::MODE_STOP_REQ;
                                        res_reg.client_state <= mcrr_pkg::MODE_STOP_REQ;
                                        res_reg.accepted <= 1'b1;
                                    end else if (mode_reg[cur] >= mcrr_pkg::MODE_STOP_REQ &&
                                                 mode_reg[cur] <= mcrr_pkg::MODE_READY) begin
                                        res_reg.accepted <= 1'b1;
                                    end else begin
                                        fault_reg[cur] <= mcrr_pkg::ERR_INVALID;
                                        res_reg.error_code <= mcrr_pkg::ERR_INVALID;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    if (mode_reg[cur] == mcrr_pkg::MODE_STOP_REQ) mode_reg[cur] <= mcrr_pkg::MODE_DRAIN;
                    if ((mode_reg[cur] == mcrr_pkg::MODE_RECORD || mode_reg[cur] == mcrr_pkg::MODE_STOP_REQ ||
                         mode_reg[cur] == mcrr_pkg::MODE_DRAIN) && cpend > best_p_reg) begin
                        best_p_reg <= cpend;
                        best_reg <= cur;
                        best_v_reg <= (budget_c != '0);
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                end
                S_RDWAIT: begin
                    // read data stays put until the output register can take it
                    if (out_free) begin
                        rpos_reg[cur] <= inc_f(rpos_reg[cur]);
                        if (wr_reg[cur] != mcrr_pkg::MAX24) wr_reg[cur] <= wr_reg[cur] + 24'd1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_RDOUT: begin
                    if (out_free) begin
                        res_v_reg <= 1'b1;
                        res_reg <= status;
                        res_reg.kind <= 1'b1;
                        res_reg.accepted <= 1'b1;
                        res_reg.out_left <= ram_rdata[23:0];
                        res_reg.out_right <= ram_rdata[47:24];
                        res_reg.last <= (cnt_reg == BW'(ncount));
                        drained_reg <= 1'b1;
                    end
                end
                S_FIN: begin
                    if ((mode_reg[cur] == mcrr_pkg::MODE_DRAIN && cpend == '0) ||
                        mode_reg[cur] == mcrr_pkg::MODE_FINAL) begin
                        if (!stepped_v_reg) begin
                            stepped_v_reg <= 1'b1;
                            stepped_reg <= cur;
                            if (!half_reg[cur]) begin
                                half_reg[cur] <= 1'b1;
                                mode_reg[cur] <= mcrr_pkg::MODE_FINAL;
                            end else begin
                                half_reg[cur] <= 1'b0;
                                mode_reg[cur] <= mcrr_pkg::MODE_READY;
                                fault_reg[cur] <= (ovf_reg[cur] != '0) ? mcrr_pkg::ERR_OVERFLOW
                                                                       : mcrr_pkg::ERR_NONE;
                            end
                        end else begin
                            mode_reg[cur] <= mcrr_pkg::MODE_FINAL;
                        end
                    end
                    if (!last_idx) idx_reg <= idx_reg + 1'b1;
                    else idx_reg <= stepped_v_reg ? stepped_reg : cur;
                end
                S_EMIT: begin
                    if (!drained_reg && out_free) begin
                        res_v_reg <= 1'b1;
                        res_reg <= status;
                        res_reg.last <= 1'b1;
                        res_reg.accepted <= stepped_v_reg;
                        if (!stepped_v_reg) begin
                            res_reg <= '0;
                            res_reg.last <= 1'b1;
                            res_reg.client_state <= mode_reg[0];
                            res_reg.error_code <= fault_reg[0];
                            res_reg.pending_frames <= 10'(pend_f(wpos_reg[0], rpos_reg[0]));
                            res_reg.ovf_total <= ovf_reg[0];
                            res_reg.drop_total <= drop_reg[0];
                            res_reg.drain_total <= wr_reg[0];
                        end
                        drained_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
            state_reg <= state_next;
            if (state_reg == S_FIN && last_idx && !stepped_v_reg && !drained_reg)
                idx_reg <= '0;
            if (state_reg == S_FIN && last_idx &&
                ((mode_reg[cur] == mcrr_pkg::MODE_DRAIN && cpend == '0) ||
                 mode_reg[cur] == mcrr_pkg::MODE_FINAL) && !stepped_v_reg)
                idx_reg <= cur;
        end
    end

    assign m_axis_tvalid = res_v_reg;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {6'd0, res_reg.drain_total, res_reg.drop_total,
                            res_reg.ovf_total, res_reg.pending_frames,
                            res_reg.error_code, res_reg.client_state, res_reg.accepted,
                            res_reg.out_right, res_reg.out_left, res_reg.res_client};

endmodule

FILE: src/mcrr_checker.sv
// Port-level checker for the multi-client record ring, bound to the top level.
module mcrr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic         m_axis_tlast,
    input logic         m_axis_tuser,
    input logic [135:0] m_axis_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while busy");

    a_frame_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[50])
        else $error("drained frame not marked accepted");

    a_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tlast)
        else $error("input ready mid-operation");

endmodule

bind multi_client_record_ring_top mcrr_checker u_mcrr_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .m_axis_tdata(m_axis_tdata)
);
